FILE: rtl/pcap_pkg.sv
`timescale 1ns / 1ps

package pcap_pkg;

    localparam int NUM_LANES  = 3;
    localparam int CHAN_W     = 8;
    localparam int LEVELS_W   = 9;
    localparam int CFG_DATA_W = 9;
    localparam int CFG_IDX_W  = 2;

    // Iterative divider sizing: 34-bit dividend, 17-bit divisor, quotient below 2^18.
    localparam int DIV_NUM_W = 34;
    localparam int DIV_DEN_W = 17;
    localparam int DIV_Q_W   = 18;
    localparam int DIV_CNT_W = 5;

    localparam int FACTOR_W = 18;
    localparam int RECIP_W  = 17;
    localparam int LUMA_W   = 24;

    localparam logic [15:0] LUMA_COEF [NUM_LANES] = '{16'd19595, 16'd38470, 16'd7471};

    // floor(x / 100) == (x * 83887) >> 23 for every x below 2^16.
    localparam logic [16:0] DIV100_MUL = 17'd83887;
    localparam int          DIV100_SH  = 23;

    localparam logic [7:0]          SAT_RESET     = 8'd100;
    localparam logic [7:0]          BRIGHT_RESET  = 8'd0;
    localparam logic [LEVELS_W-1:0] LEVELS_RESET  = 9'd32;
    localparam logic [FACTOR_W-1:0] FACTOR_RESET  = 18'd65536;
    localparam logic [7:0]          STEP_RESET    = 8'd8;
    localparam logic [RECIP_W-1:0]  RECIP_RESET   = 17'd8192;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SATURATION = 2'd0,
        REG_BRIGHTNESS = 2'd1,
        REG_CONTRAST   = 2'd2,
        REG_LEVELS     = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic [7:0]          sat;
        logic [7:0]          bright;
        logic [FACTOR_W-1:0] factor;
        logic [RECIP_W-1:0]  recip;
        logic [7:0]          step;
        logic                post_en;
    } t_lane_cfg;

    typedef struct packed {
        logic [6:0] adv;
        logic       trans;
    } t_lane_ctl;

endpackage

FILE: rtl/pixel_color_adjust_posterize_top.sv
// Color adjuster for an RGB pixel stream: saturation about luma, brightness offset,
// contrast about mid-gray, clamp to 0..255 and optional posterize. One pixel is taken
// per clock while the output is not stalled and no divide is running; each of the three
// channels has its own seven-stage lane after two shared luma stages. Transparent
// pixels come back unchanged with the kept flag low. Writing the contrast register starts
// an 18-step iterative divide for the contrast factor, and writing the levels register
// runs two such divides back to back (step size, then its reciprocal); input is held
// off during a configuration write and until the divides are done.
// Saturation and brightness writes take effect at once.
`timescale 1ns / 1ps

module pixel_color_adjust_posterize_top import pcap_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [23:0]           i_s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                  i_s_axis_tuser,  // transparent
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [23:0]           o_m_axis_tdata,  // red_out, green_out, blue_out
    output logic                  o_m_axis_tuser   // kept
);

    logic [7:0]          r_sat;
    logic [7:0]          r_bright;
    logic [LEVELS_W-1:0] r_levels;
    logic [FACTOR_W-1:0] r_factor;
    logic [7:0]          r_step;
    logic [RECIP_W-1:0]  r_recip;

    logic [8:0]        r_vld;
    logic [7:0]        r_trans;
    logic              r_kept;
    logic [CHAN_W-1:0] r_pix0 [NUM_LANES];
    logic [CHAN_W-1:0] r_pix1 [NUM_LANES];
    logic [23:0]       r_prod [NUM_LANES];
    logic [CHAN_W-1:0] r_luma;

    logic [8:0]     adv;
    logic           accept;
    logic           cfg_busy;
    logic [23:0]    luma_sum;
    t_lane_cfg      lane_cfg;
    t_lane_ctl      lane_ctl;
    logic [CHAN_W-1:0] lane_out [NUM_LANES];

    logic                 c_start, c_busy, c_done;
    logic                 s_start, s_busy, s_done;
    logic                 q_busy, q_done;
    logic [DIV_Q_W-1:0]   c_quot, s_quot, q_quot;
    logic [DIV_NUM_W-1:0] c_num;
    logic [DIV_DEN_W-1:0] c_den;
    logic [DIV_DEN_W-1:0] s_den;
    logic [DIV_NUM_W-1:0] q_num;
    logic [DIV_DEN_W-1:0] q_den;
    logic [9:0]           c_sx;
    logic [9:0]           c_plus;
    logic [9:0]           c_minus;
    logic [16:0]          c_num_base;
    logic [LEVELS_W-1:0]  lv;
    logic [7:0]           step_new;
    logic [24:0]          recip_chk;

    // Contrast factor: floor(259*(C+255)*65536 / (255*(259-C))).
    always_comb begin
        c_sx       = {{2{i_cfg_data[7]}}, i_cfg_data[7:0]};
        c_plus     = c_sx + 10'd255;
        c_minus    = 10'd259 - c_sx;
        c_num_base = 17'(c_plus[8:0]) * 17'd259;
        c_num      = {1'b0, c_num_base, 16'd0};
        c_den      = 17'(c_minus[8:0]) * 17'd255;
        c_start    = i_cfg_we && (t_cfg_reg'(i_cfg_index) == REG_CONTRAST);

        lv      = (i_cfg_data < 9'd2) ? 9'd2 : i_cfg_data;
        s_den   = 17'(lv);
        s_start = i_cfg_we && (t_cfg_reg'(i_cfg_index) == REG_LEVELS);

        // The reciprocal ceil(65536/step) turns the posterize divide into a multiply.
        step_new = (s_quot[7:0] == 8'd0) ? 8'd1 : s_quot[7:0];
        q_num    = DIV_NUM_W'(17'd65535 + 17'(step_new));
        q_den    = 17'(step_new);
    end

    pcap_div u_div_contrast (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (c_start),
        .i_num   (c_num),
        .i_den   (c_den),
        .o_busy  (c_busy),
        .o_done  (c_done),
        .o_quot  (c_quot)
    );

    pcap_div u_div_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_start),
        .i_num   (DIV_NUM_W'(256)),
        .i_den   (s_den),
        .o_busy  (s_busy),
        .o_done  (s_done),
        .o_quot  (s_quot)
    );

    pcap_div u_div_recip (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_done),
        .i_num   (q_num),
        .i_den   (q_den),
        .o_busy  (q_busy),
        .o_done  (q_done),
        .o_quot  (q_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat    <= SAT_RESET;
            r_bright <= BRIGHT_RESET;
            r_levels <= LEVELS_RESET;
            r_factor <= FACTOR_RESET;
            r_step   <= STEP_RESET;
            r_recip  <= RECIP_RESET;
        end else begin
            if (i_cfg_we) begin
                unique case (t_cfg_reg'(i_cfg_index))
                    REG_SATURATION: r_sat    <= i_cfg_data[7:0];
                    REG_BRIGHTNESS: r_bright <= i_cfg_data[7:0];
                    REG_CONTRAST:   r_bright <= r_bright;
                    REG_LEVELS:     r_levels <= i_cfg_data;
                endcase
            end
            if (c_done) begin
                r_factor <= c_quot;
            end
            if (s_done) begin
                r_step <= step_new;
            end
            if (q_done) begin
                r_recip <= q_quot[RECIP_W-1:0];
            end
        end
    end

    assign cfg_busy = c_busy | s_busy | q_busy;

    // A stage takes new data when it is empty or its successor moves on.
    always_comb begin
        adv[8] = !r_vld[8] || i_m_axis_tready;
        for (int k = 7; k >= 0; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    assign o_s_axis_tready = adv[0] && !cfg_busy && !i_cfg_we;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= accept;
            end
            for (int k = 1; k < 9; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Luma merge: each lane's weighted channel, then one sum.
    assign luma_sum = r_prod[0] + r_prod[1] + r_prod[2];

    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                r_pix0[k] <= i_s_axis_tdata[k*CHAN_W +: CHAN_W];
                r_prod[k] <= 24'(LUMA_COEF[k]) * 24'(i_s_axis_tdata[k*CHAN_W +: CHAN_W]);
            end
            r_trans[0] <= i_s_axis_tuser;
        end
        if (adv[1]) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                r_pix1[k] <= r_pix0[k];
            end
            r_luma     <= luma_sum[23:16];
            r_trans[1] <= r_trans[0];
        end
        for (int k = 2; k < 8; k++) begin
            if (adv[k]) begin
                r_trans[k] <= r_trans[k-1];
            end
        end
        if (adv[8]) begin
            r_kept <= !r_trans[7];
        end
    end

    always_comb begin
        lane_cfg.sat     = r_sat;
        lane_cfg.bright  = r_bright;
        lane_cfg.factor  = r_factor;
        lane_cfg.recip   = r_recip;
        lane_cfg.step    = r_step;
        lane_cfg.post_en = !r_levels[LEVELS_W-1];
        lane_ctl.adv     = adv[8:2];
        lane_ctl.trans   = r_trans[7];
    end

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        pcap_lane u_lane (
            .i_clk  (i_clk),
            .i_ctl  (lane_ctl),
            .i_cfg  (lane_cfg),
            .i_chan (r_pix1[g]),
            .i_luma (r_luma),
            .o_chan (lane_out[g])
        );
        assign o_m_axis_tdata[g*CHAN_W +: CHAN_W] = lane_out[g];
    end

    assign o_m_axis_tvalid = r_vld[8];
    assign o_m_axis_tuser  = r_kept;

    assign recip_chk = 25'(r_recip) * 25'(r_step);

    a_step_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_step != 8'd0)
        else $error("posterize step is zero");

    a_recip_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_done |=> (recip_chk >= 25'd65536) && (recip_chk < 25'd65536 + 25'(r_step)))
        else $error("posterize reciprocal does not match step");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        c_done |-> !$past(accept))
        else $error("pixel accepted while contrast factor was being derived");

endmodule

FILE: rtl/pcap_div.sv
`timescale 1ns / 1ps

module pcap_div import pcap_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [DIV_NUM_W-1:0] i_num,
    input  logic [DIV_DEN_W-1:0] i_den,
    output logic                 o_busy,
    output logic                 o_done,
    output logic [DIV_Q_W-1:0]   o_quot
);

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_Q_W-1:0]   r_q;
    logic [DIV_DEN_W-1:0] r_den;

    logic [DIV_DEN_W:0]   trial;
    logic [DIV_DEN_W:0]   diff;
    logic                 ge;
    logic [DIV_DEN_W-1:0] n_rem;
    logic [DIV_Q_W-1:0]   n_q;

    // One quotient bit per cycle. The dividend's upper bits start in the
    // remainder because the quotient is known to fit in DIV_Q_W bits.
    always_comb begin
        trial = {r_rem, r_q[DIV_Q_W-1]};
        diff  = trial - {1'b0, r_den};
        ge    = (trial >= {1'b0, r_den});
        n_rem = ge ? diff[DIV_DEN_W-1:0] : trial[DIV_DEN_W-1:0];
        n_q   = {r_q[DIV_Q_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == DIV_CNT_W'(DIV_Q_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= {1'b0, i_num[DIV_NUM_W-1:DIV_Q_W]};
            r_q   <= i_num[DIV_Q_W-1:0];
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= n_q;
        end
    end

    assign o_busy = r_busy | r_done;
    assign o_done = r_done;
    assign o_quot = r_q;

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> $past(r_busy))
        else $error("divider finished without running");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt < DIV_CNT_W'(DIV_Q_W)))
        else $error("divider iteration count out of range");

endmodule

FILE: rtl/pcap_lane.sv
`timescale 1ns / 1ps

module pcap_lane import pcap_pkg::*; (
    input  logic              i_clk,
    input  t_lane_ctl         i_ctl,
    input  t_lane_cfg         i_cfg,
    input  logic [CHAN_W-1:0] i_chan,
    input  logic [CHAN_W-1:0] i_luma,
    output logic [CHAN_W-1:0] o_chan
);

    logic [CHAN_W-1:0] r_c [6];
    logic [CHAN_W-1:0] r_luma [2];
    logic              r_neg [2];

    logic [15:0]        r0_mp;
    logic [32:0]        r1_q;
    logic signed [11:0] r2_v;
    logic signed [30:0] r3_t;
    logic [CHAN_W-1:0]  r4_c8;
    logic [CHAN_W-1:0]  r5_q;
    logic [CHAN_W-1:0]  r5_c8;
    logic [CHAN_W-1:0]  r6_out;

    logic [CHAN_W-1:0]  mag;
    logic               neg;
    logic [15:0]        mp;
    logic [32:0]        qprod;
    logic [9:0]         part;
    logic signed [11:0] luma_s;
    logic signed [11:0] part_s;
    logic signed [11:0] bright_s;
    logic signed [11:0] v;
    logic signed [30:0] tprod;
    logic signed [30:0] t;
    logic [CHAN_W-1:0]  c8;
    logic [24:0]        rprod;
    logic [15:0]        pm;
    logic [CHAN_W-1:0]  out_c;

    always_comb begin
        // Distance from luma, kept as sign and magnitude so the /100 truncates toward zero.
        neg   = (i_chan < i_luma);
        mag   = neg ? (i_luma - i_chan) : (i_chan - i_luma);
        mp    = {8'd0, mag} * {8'd0, i_cfg.sat};
        qprod = 33'(r0_mp) * 33'(DIV100_MUL);

        part     = r1_q[DIV100_SH+9:DIV100_SH];
        luma_s   = $signed({4'd0, r_luma[1]});
        part_s   = $signed({2'd0, part});
        bright_s = $signed({{4{i_cfg.bright[7]}}, i_cfg.bright});
        v        = luma_s + (r_neg[1] ? -part_s : part_s) + bright_s - 12'sd128;

        tprod = 31'($signed({1'b0, i_cfg.factor})) * 31'(r2_v);

        t = r3_t + 31'sd8388608;
        if (t[30]) begin
            c8 = '0;
        end else if (|t[30:24]) begin
            c8 = 8'd255;
        end else begin
            c8 = t[23:16];
        end

        rprod = 25'(r4_c8) * 25'(i_cfg.recip);
        pm    = {8'd0, r5_q} * {8'd0, i_cfg.step};

        if (i_ctl.trans) begin
            out_c = r_c[5];
        end else if (i_cfg.post_en) begin
            out_c = pm[CHAN_W-1:0];
        end else begin
            out_c = r5_c8;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[0]) begin
            r_c[0]    <= i_chan;
            r_luma[0] <= i_luma;
            r_neg[0]  <= neg;
            r0_mp     <= mp;
        end
        if (i_ctl.adv[1]) begin
            r_c[1]    <= r_c[0];
            r_luma[1] <= r_luma[0];
            r_neg[1]  <= r_neg[0];
            r1_q      <= qprod;
        end
        if (i_ctl.adv[2]) begin
            r_c[2] <= r_c[1];
            r2_v   <= v;
        end
        if (i_ctl.adv[3]) begin
            r_c[3] <= r_c[2];
            r3_t   <= tprod;
        end
        if (i_ctl.adv[4]) begin
            r_c[4] <= r_c[3];
            r4_c8  <= c8;
        end
        if (i_ctl.adv[5]) begin
            r_c[5] <= r_c[4];
            r5_q   <= rprod[23:16];
            r5_c8  <= r4_c8;
        end
        if (i_ctl.adv[6]) begin
            r6_out <= out_c;
        end
    end

    assign o_chan = r6_out;

endmodule
